FILE: rtl/xtea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, constants and the mixing function of the XTEA cipher block.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int ROUNDS_DEFAULT = 32;
  localparam int KEY_WORDS      = 4;
  localparam int WORD_W         = 32;
  localparam int CFG_INDEX_W    = 3;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD0    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD1    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD2    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD3    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECRYPT_MODE = 3'd4;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] xtea_key_t;

  typedef struct packed {
    logic [WORD_W-1:0] block_left;
    logic [WORD_W-1:0] block_right;
  } xtea_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_left;
    logic [WORD_W-1:0] result_right;
  } xtea_out_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
  } xtea_stage_t;

  typedef struct packed {
    xtea_key_t key;
    logic      decrypt;
  } xtea_ctrl_t;

  function automatic logic [WORD_W-1:0] xtea_mix(input logic [WORD_W-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

FILE: rtl/xtea_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_stream_if
// Valid/ready channels for input blocks and for processed blocks.
// ----------------------------------------------------------------------------
interface xtea_in_if;
  logic               valid;
  logic               ready;
  xtea_pkg::xtea_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface xtea_out_if;
  logic                valid;
  logic                ready;
  xtea_pkg::xtea_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/xtea_half_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_half_round
// One registered half-round: updates one half from the mix of the other,
// with the running sum and key selection fixed by the stage position.
// ----------------------------------------------------------------------------
module xtea_half_round #(
  parameter int ROUNDS = xtea_pkg::ROUNDS_DEFAULT,
  parameter int STAGE  = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  xtea_pkg::xtea_ctrl_t  ctrl,
  input  xtea_pkg::xtea_stage_t stage_in,
  output xtea_pkg::xtea_stage_t stage_out
);

  localparam bit EVEN = (STAGE % 2) == 0;
  localparam logic [xtea_pkg::WORD_W-1:0] ENC_SUM =
    32'(64'(xtea_pkg::DELTA) * 64'((STAGE + 1) / 2));
  localparam logic [xtea_pkg::WORD_W-1:0] DEC_SUM =
    32'(64'(xtea_pkg::DELTA) * 64'(EVEN ? (ROUNDS - STAGE / 2) : (ROUNDS - (STAGE + 1) / 2)));
  localparam logic [1:0] ENC_IDX = EVEN ? ENC_SUM[1:0] : ENC_SUM[12:11];
  localparam logic [1:0] DEC_IDX = EVEN ? DEC_SUM[12:11] : DEC_SUM[1:0];

  logic                          upd_left;
  logic [xtea_pkg::WORD_W-1:0]   sum;
  logic [1:0]                    idx;
  logic [xtea_pkg::WORD_W-1:0]   src;
  logic [xtea_pkg::WORD_W-1:0]   tgt;
  logic [xtea_pkg::WORD_W-1:0]   f;
  logic [xtea_pkg::WORD_W-1:0]   upd;
  xtea_pkg::xtea_stage_t         stage_nxt;
  xtea_pkg::xtea_stage_t         stage_r;

  always_comb begin
    upd_left = ctrl.decrypt ? !EVEN : EVEN;
    sum      = ctrl.decrypt ? DEC_SUM : ENC_SUM;
    idx      = ctrl.decrypt ? DEC_IDX : ENC_IDX;
    src      = upd_left ? stage_in.right : stage_in.left;
    tgt      = upd_left ? stage_in.left : stage_in.right;
    f        = xtea_pkg::xtea_mix(src) ^ (sum + ctrl.key[idx]);
    upd      = ctrl.decrypt ? (tgt - f) : (tgt + f);
    stage_nxt.valid = stage_in.valid;
    stage_nxt.left  = upd_left ? upd : stage_in.left;
    stage_nxt.right = upd_left ? stage_in.right : upd;
  end

  // valid bit under reset, halves are plain payload
  always_ff @(posedge clk) begin
    if (en) begin
      stage_r.left  <= stage_nxt.left;
      stage_r.right <= stage_nxt.right;
    end
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
  end

  assign stage_out = stage_r;

endmodule

FILE: rtl/xtea_out_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_out_buffer
// Output register with a skid stage, so the pipeline sees a registered ready.
// ----------------------------------------------------------------------------
module xtea_out_buffer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  xtea_pkg::xtea_stage_t tail,
  output logic                  tail_ready,
  xtea_out_if.source            out_chan
);

  logic                 out_valid_r;
  xtea_pkg::xtea_out_t  out_data_r;
  logic                 skid_valid_r;
  xtea_pkg::xtea_out_t  skid_data_r;
  xtea_pkg::xtea_out_t  tail_data;
  logic                 tail_take;
  logic                 out_free;

  always_comb begin
    tail_data.result_left  = tail.left;
    tail_data.result_right = tail.right;
    tail_ready = !skid_valid_r;
    tail_take  = tail.valid && tail_ready;
    out_free   = !out_valid_r || out_chan.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= tail_take;
      end
    end else if (tail_take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : tail_data;
    end
    if (!out_free && tail_take) begin
      skid_data_r <= tail_data;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

FILE: rtl/xtea_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_block_cipher
// XTEA encrypt/decrypt over ROUNDS rounds, one half-round per pipeline stage.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    block_left, block_right
//  out_chan  out  valid/ready    result_left, result_right
//  cfg_*     in   cfg_we only    cfg_index selects key_word0..3, decrypt_mode
//
//  one block accepted per cycle while the skid stage is empty; each block passes
//  through the half-round stages and then the output register
//  synchronous active-low reset clears key, mode and all valid bits
//  a stalled output fills the skid stage, then the whole pipeline holds
// ----------------------------------------------------------------------------
module xtea_block_cipher #(
  parameter int ROUNDS = xtea_pkg::ROUNDS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [xtea_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0]        cfg_data,
  xtea_in_if.sink                            in_chan,
  xtea_out_if.source                         out_chan
);

  localparam int STAGES = 2 * ROUNDS;

  xtea_pkg::xtea_key_t   key_r;
  logic                  decrypt_r;
  xtea_pkg::xtea_ctrl_t  ctrl;
  xtea_pkg::xtea_stage_t pipe [STAGES+1];
  logic                  pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      decrypt_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xtea_pkg::CFG_KEY_WORD0:    key_r[0]  <= cfg_data;
        xtea_pkg::CFG_KEY_WORD1:    key_r[1]  <= cfg_data;
        xtea_pkg::CFG_KEY_WORD2:    key_r[2]  <= cfg_data;
        xtea_pkg::CFG_KEY_WORD3:    key_r[3]  <= cfg_data;
        xtea_pkg::CFG_DECRYPT_MODE: decrypt_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl.key     = key_r;
    ctrl.decrypt = decrypt_r;
    pipe[0].valid = in_chan.valid;
    pipe[0].left  = in_chan.data.block_left;
    pipe[0].right = in_chan.data.block_right;
  end

  assign in_chan.ready = pipe_en;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    xtea_half_round #(
      .ROUNDS (ROUNDS),
      .STAGE  (s)
    ) u_half_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .ctrl      (ctrl),
      .stage_in  (pipe[s]),
      .stage_out (pipe[s+1])
    );
  end

  xtea_out_buffer u_out_buffer (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail       (pipe[STAGES]),
    .tail_ready (pipe_en),
    .out_chan   (out_chan)
  );

endmodule

FILE: tb/xtea_block_cipher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_block_cipher_tb
// Self-checking bench for the XTEA cipher. Blocks are offered on the input
// channel with random gaps while the result channel stalls at random. Each
// accepted request is enciphered or deciphered by a behavioural model of the
// 32-round XTEA schedule under the current key and mode. Each returned block
// is checked in arrival order against those predictions. The key and mode
// are reprogrammed between phases, only once the pipeline has drained.
// ----------------------------------------------------------------------------
module xtea_block_cipher_tb;

  localparam int ROUNDS      = xtea_pkg::ROUNDS_DEFAULT;
  localparam int LATENCY     = 2 * ROUNDS + 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 75;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [xtea_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [xtea_pkg::WORD_W-1:0]      cfg_data;

  xtea_in_if  in_chan ();
  xtea_out_if out_chan ();

  xtea_block_cipher #(.ROUNDS(ROUNDS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [xtea_pkg::WORD_W-1:0] key_model [xtea_pkg::KEY_WORDS];
  logic                        decrypt_model;

  xtea_pkg::xtea_in_t  pending_blocks [$];
  xtea_pkg::xtea_out_t expected_blocks [$];

  int  in_idle_pct;
  int  out_idle_pct;
  bit  in_taken;
  int  blocks_sent;
  int  blocks_checked;
  int  settings_used;
  int  error_count;
  int  cycle_count;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic logic [xtea_pkg::WORD_W-1:0] shift_mix(
    input logic [xtea_pkg::WORD_W-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function automatic xtea_pkg::xtea_out_t cipher_block(input xtea_pkg::xtea_in_t blk);
    logic [xtea_pkg::WORD_W-1:0] y;
    logic [xtea_pkg::WORD_W-1:0] z;
    logic [xtea_pkg::WORD_W-1:0] sum;
    xtea_pkg::xtea_out_t         res;
    y = blk.block_left;
    z = blk.block_right;
    if (!decrypt_model) begin
      sum = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        y = y + (shift_mix(z) ^ (sum + key_model[sum[1:0]]));
        sum = sum + xtea_pkg::DELTA;
        z = z + (shift_mix(y) ^ (sum + key_model[sum[12:11]]));
      end
    end else begin
      sum = xtea_pkg::DELTA * 32'(ROUNDS);
      for (int r = 0; r < ROUNDS; r++) begin
        z = z - (shift_mix(y) ^ (sum + key_model[sum[12:11]]));
        sum = sum - xtea_pkg::DELTA;
        y = y - (shift_mix(z) ^ (sum + key_model[sum[1:0]]));
      end
    end
    res.result_left  = y;
    res.result_right = z;
    return res;
  endfunction

  function automatic logic [xtea_pkg::WORD_W-1:0] rand_word();
    logic [xtea_pkg::WORD_W-1:0] w;
    case ($urandom_range(9))
      0: begin
        w = '0;
      end
      1: begin
        w = '1;
      end
      2: begin
        w = 32'h1 << $urandom_range(xtea_pkg::WORD_W - 1);
      end
      3: begin
        w = ~(32'h1 << $urandom_range(xtea_pkg::WORD_W - 1));
      end
      default: begin
        w = $urandom;
      end
    endcase
    return w;
  endfunction

  task automatic report_failure(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic cfg_write(input logic [xtea_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [xtea_pkg::WORD_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      xtea_pkg::CFG_KEY_WORD0, xtea_pkg::CFG_KEY_WORD1,
      xtea_pkg::CFG_KEY_WORD2, xtea_pkg::CFG_KEY_WORD3: begin
        key_model[idx[1:0]] = data;
      end
      xtea_pkg::CFG_DECRYPT_MODE: begin
        decrypt_model = data[0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mode word carries random upper bits, only bit 0 counts
  task automatic load_setting(input logic [xtea_pkg::WORD_W-1:0] k0,
                              input logic [xtea_pkg::WORD_W-1:0] k1,
                              input logic [xtea_pkg::WORD_W-1:0] k2,
                              input logic [xtea_pkg::WORD_W-1:0] k3,
                              input logic mode);
    cfg_write(xtea_pkg::CFG_KEY_WORD0, k0);
    cfg_write(xtea_pkg::CFG_KEY_WORD1, k1);
    cfg_write(xtea_pkg::CFG_KEY_WORD2, k2);
    cfg_write(xtea_pkg::CFG_KEY_WORD3, k3);
    cfg_write(xtea_pkg::CFG_DECRYPT_MODE, {31'($urandom), mode});
    settings_used++;
  endtask

  task automatic queue_block(input logic [xtea_pkg::WORD_W-1:0] l,
                             input logic [xtea_pkg::WORD_W-1:0] r);
    xtea_pkg::xtea_in_t blk;
    blk.block_left  = l;
    blk.block_right = r;
    pending_blocks.push_back(blk);
  endtask

  task automatic wait_drained();
    while (pending_blocks.size() != 0 || in_chan.valid || expected_blocks.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_directed();
    queue_block(32'h0000_0000, 32'h0000_0000);
    queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_block(32'h0000_0000, 32'hFFFF_FFFF);
    queue_block(32'hFFFF_FFFF, 32'h0000_0000);
    queue_block(32'hAAAA_AAAA, 32'h5555_5555);
    queue_block(32'h8000_0000, 32'h0000_0001);
  endtask

  // request acceptance and prediction
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      expected_blocks.push_back(cipher_block(in_chan.data));
      blocks_sent++;
      in_taken = 1'b1;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      in_taken = 1'b0;
      if (pending_blocks.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_chan.valid <= 1'b1;
        in_chan.data  <= pending_blocks.pop_front();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    out_chan.ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    xtea_pkg::xtea_out_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_blocks.size() == 0) begin
        report_failure($sformatf("unexpected result %h_%h",
                                 out_chan.data.result_left, out_chan.data.result_right));
      end else begin
        want = expected_blocks.pop_front();
        if (out_chan.data.result_left !== want.result_left)
          report_failure($sformatf("result_left got %h want %h",
                                   out_chan.data.result_left, want.result_left));
        if (out_chan.data.result_right !== want.result_right)
          report_failure($sformatf("result_right got %h want %h",
                                   out_chan.data.result_right, want.result_right));
        blocks_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_blocks.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    in_taken       = 1'b0;
    in_idle_pct    = 11;
    out_idle_pct   = 71;
    blocks_sent    = 0;
    blocks_checked = 0;
    settings_used  = 1;
    error_count    = 0;
    cycle_count    = 0;
    for (int i = 0; i < xtea_pkg::KEY_WORDS; i++)
      key_model[i] = '0;
    decrypt_model = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all-zero key straight after reset
    queue_directed();
    wait_drained();

    load_setting('1, '1, '1, '1, 1'b1);
    queue_directed();
    wait_drained();

    load_setting(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0);
    // writes past the last register must leave the key alone
    for (int idx = xtea_pkg::CFG_DECRYPT_MODE + 1; idx < (1 << xtea_pkg::CFG_INDEX_W); idx++)
      cfg_write(xtea_pkg::CFG_INDEX_W'(idx), '1);
    queue_directed();
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p / 2)
        0: begin
          in_idle_pct  = 11;
          out_idle_pct = 71;
        end
        1: begin
          in_idle_pct  = 71;
          out_idle_pct = 11;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      case (p)
        2: begin
          load_setting('1, '1, '1, '1, 1'b0);
        end
        3: begin
          load_setting('0, '0, '0, '0, 1'b1);
        end
        default: begin
          load_setting(rand_word(), rand_word(), rand_word(), rand_word(), p[0]);
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++)
        queue_block(rand_word(), rand_word());
      wait_drained();
    end

    repeat (LATENCY + 10) @(posedge clk);

    $display("%0d requests accepted, %0d results checked across %0d key/mode settings",
             blocks_sent, blocks_checked, settings_used);
    $display("stall mixes: sender-light, receiver-light and back-to-back");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: xtea_block_cipher.f
rtl/xtea_pkg.sv
rtl/xtea_stream_if.sv
rtl/xtea_half_round.sv
rtl/xtea_out_buffer.sv
rtl/xtea_block_cipher.sv
tb/xtea_block_cipher_tb.sv
